/* rtl/core/sig_pkg.sv */
// Shared types and constants for the slice index generator.
package sig_pkg;

    localparam int MAX_LENGTH = 64;
    localparam int LEN_W      = 7;
    localparam int POS_W      = 8;
    localparam int NORM_W     = POS_W + 1;
    localparam int NEXT_W     = POS_W + 2;

    localparam logic [LEN_W-1:0] MAX_LEN_V = LEN_W'(MAX_LENGTH);

    typedef enum logic [2:0] {
        ADDR_START_POS  = 3'd0,
        ADDR_START_OPEN = 3'd1,
        ADDR_STOP_POS   = 3'd2,
        ADDR_STOP_OPEN  = 3'd3,
        ADDR_STRIDE     = 3'd4
    } t_cfg_addr;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_EMPTY       = 3'd1,
        ST_STOP_BEYOND = 3'd2,
        ST_START_NEG   = 3'd3,
        ST_ZERO_STEP   = 3'd4
    } t_status_code;

    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_CHECK = 2'd1,
        S_EMIT  = 2'd2
    } t_state;

    typedef struct packed {
        logic load;
        logic check;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic check_err;
        logic emit_last;
    } t_stat;

endpackage

/* rtl/core/sig_ctrl.sv */
// Control state machine: accept, check, emit.
module sig_ctrl
    import sig_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_CHECK;
            end
            S_CHECK: begin
                if (i_stat.out_free) n_state = i_stat.check_err ? S_IDLE : S_EMIT;
            end
            S_EMIT: begin
                if (i_stat.out_free && i_stat.emit_last) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_CHECK: begin
                o_cmd.check = i_stat.out_free;
            end
            S_EMIT: begin
                o_cmd.emit = i_stat.out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

/* rtl/core/sig_dpath.sv */
// Datapath: config registers, bound normalization, index stepping, output register.
module sig_dpath
    import sig_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    input  logic [2:0]       i_cfg_addr,
    input  logic [POS_W-1:0] i_cfg_data,
    input  logic [LEN_W-1:0] i_seq_length,
    input  logic             i_one_based,
    input  t_cmd             i_cmd,
    output t_stat            o_stat,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    output logic [LEN_W-1:0] o_index,
    output logic             o_last,
    output logic [2:0]       o_status
);

    // configuration
    logic [POS_W-1:0] r_start_pos;
    logic             r_start_open;
    logic [POS_W-1:0] r_stop_pos;
    logic             r_stop_open;
    logic [POS_W-1:0] r_stride;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_pos  <= '0;
            r_start_open <= 1'b0;
            r_stop_pos   <= '0;
            r_stop_open  <= 1'b1;
            r_stride     <= POS_W'(1);
        end else if (i_cfg_valid) begin
            case (t_cfg_addr'(i_cfg_addr))
                ADDR_START_POS:  r_start_pos  <= i_cfg_data;
                ADDR_START_OPEN: r_start_open <= i_cfg_data[0];
                ADDR_STOP_POS:   r_stop_pos   <= i_cfg_data;
                ADDR_STOP_OPEN:  r_stop_open  <= i_cfg_data[0];
                ADDR_STRIDE:     r_stride     <= i_cfg_data;
                default:         r_stride     <= r_stride;
            endcase
        end
    end

    logic step_neg;
    logic step_zero;
    assign step_neg  = r_stride[POS_W-1];
    assign step_zero = (r_stride == '0);

    // request registers
    logic signed [NORM_W-1:0] r_cur,  n_cur;
    logic signed [NORM_W-1:0] r_stop, n_stop;
    logic        [LEN_W-1:0]  r_len,  n_len;
    logic                     r_ob,   n_ob;

    // normalization at accept
    logic        [LEN_W-1:0]  len_c;
    logic signed [NORM_W-1:0] len_in9;
    logic signed [NORM_W-1:0] sp9;
    logic signed [NORM_W-1:0] ep9;
    logic signed [NORM_W-1:0] start_norm;
    logic signed [NORM_W-1:0] stop_norm;

    always_comb begin
        len_c   = (i_seq_length > MAX_LEN_V) ? MAX_LEN_V : i_seq_length;
        len_in9 = $signed({{(NORM_W-LEN_W){1'b0}}, len_c});
        sp9     = $signed({r_start_pos[POS_W-1], r_start_pos});
        ep9     = $signed({r_stop_pos[POS_W-1], r_stop_pos});
        if (r_start_open) begin
            start_norm = step_neg ? (len_in9 - NORM_W'(1)) : '0;
        end else begin
            start_norm = sp9[NORM_W-1] ? (sp9 + len_in9) : sp9;
        end
        if (r_stop_open) begin
            stop_norm = step_neg ? -NORM_W'(1) : len_in9;
        end else begin
            stop_norm = ep9[NORM_W-1] ? (ep9 + len_in9) : ep9;
        end
    end

    // checks on the latched bounds
    logic signed [NORM_W-1:0] len9;
    logic signed [NORM_W-1:0] lenm1;
    logic signed [NORM_W-1:0] cur_cl;
    logic signed [NORM_W-1:0] stop_cl;
    t_status_code             chk_code;

    always_comb begin
        len9    = $signed({{(NORM_W-LEN_W){1'b0}}, r_len});
        lenm1   = len9 - NORM_W'(1);
        // negative stride: start pulled inside the sequence, stop not below -1
        cur_cl  = (step_neg && (r_cur > lenm1)) ? lenm1 : r_cur;
        stop_cl = (step_neg && (r_stop < -NORM_W'(1))) ? -NORM_W'(1) : r_stop;
        if (r_stop > len9) begin
            chk_code = ST_STOP_BEYOND;
        end else if (r_cur < 0) begin
            chk_code = ST_START_NEG;
        end else if (step_zero) begin
            chk_code = ST_ZERO_STEP;
        end else if ((step_neg && (r_stop >= r_cur)) || (!step_neg && (r_stop <= r_cur))) begin
            chk_code = ST_EMPTY;
        end else if (step_neg && (cur_cl <= stop_cl)) begin
            chk_code = ST_EMPTY;
        end else begin
            chk_code = ST_OK;
        end
    end

    // stepping
    logic signed [NEXT_W-1:0] step10;
    logic signed [NEXT_W-1:0] nxt;
    logic signed [NEXT_W-1:0] stop10;
    logic                     run_last;
    logic        [LEN_W-1:0]  emit_index;

    always_comb begin
        step10     = $signed({{(NEXT_W-POS_W){r_stride[POS_W-1]}}, r_stride});
        stop10     = $signed({r_stop[NORM_W-1], r_stop});
        nxt        = $signed({r_cur[NORM_W-1], r_cur}) + step10;
        run_last   = step_neg ? (nxt <= stop10) : (nxt >= stop10);
        emit_index = r_cur[LEN_W-1:0] + LEN_W'(r_ob);
    end

    always_comb begin
        n_cur  = r_cur;
        n_stop = r_stop;
        n_len  = r_len;
        n_ob   = r_ob;
        if (i_cmd.load) begin
            n_cur  = start_norm;
            n_stop = stop_norm;
            n_len  = len_c;
            n_ob   = i_one_based;
        end else if (i_cmd.check) begin
            n_cur  = cur_cl;
            n_stop = stop_cl;
        end else if (i_cmd.emit) begin
            n_cur  = nxt[NORM_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur  <= n_cur;
        r_stop <= n_stop;
        r_len  <= n_len;
        r_ob   <= n_ob;
    end

    // output register
    logic             r_out_valid, n_out_valid;
    logic [LEN_W-1:0] r_index,     n_index;
    logic             r_last,      n_last;
    logic [2:0]       r_status,    n_status;
    logic             out_free;
    logic             check_err;

    assign out_free  = !r_out_valid || i_out_ready;
    assign check_err = (chk_code != ST_OK);

    always_comb begin
        n_out_valid = r_out_valid;
        n_index     = r_index;
        n_last      = r_last;
        n_status    = r_status;
        if (i_out_ready) n_out_valid = 1'b0;
        if (i_cmd.check && check_err) begin
            n_out_valid = 1'b1;
            n_index     = '0;
            n_last      = 1'b1;
            n_status    = chk_code;
        end else if (i_cmd.emit) begin
            n_out_valid = 1'b1;
            n_index     = emit_index;
            n_last      = run_last;
            n_status    = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
        r_index  <= n_index;
        r_last   <= n_last;
        r_status <= n_status;
    end

    assign o_stat.out_free  = out_free;
    assign o_stat.check_err = check_err;
    assign o_stat.emit_last = run_last;

    assign o_out_valid = r_out_valid;
    assign o_index     = r_index;
    assign o_last      = r_last;
    assign o_status    = r_status;

endmodule

/* rtl/core/slice_index_generator.sv */
// Top level of the slice index generator.
//
// Slave stream: one item is a request, seq_length in s_axis_tdata[6:0]
// (lengths above 64 count as 64), one_based in s_axis_tuser.
// Master stream: one item per emitted index, index in m_axis_tdata[6:0],
// m_axis_tlast on the final item of a request, status code in m_axis_tuser.
// An error or empty range gives a single item with index 0 and tlast set.
// Config channel: i_cfg_addr selects start_pos, start_open, stop_pos,
// stop_open or stride (0..4); other addresses are ignored. Always ready;
// write only while no request is in flight.
// Timing: the bounds are normalized and registered at accept, checked in
// the check state, then one index per cycle from the stepping adder while
// m_axis_tready does not stall the output.
// One request is in flight at a time; the next is accepted once the last
// index is in the output register.
// Reset puts the registers at start 0, stop open, stride 1 and idles.
// A stall on m_axis_tready holds the output register and the stepping.
module slice_index_generator
    import sig_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [2:0] i_cfg_addr,
    input  logic [7:0] i_cfg_data,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [6:0] seq_length, [7] zero
    input  logic       s_axis_tuser,   // [0] one_based
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [6:0] index, [7] zero
    output logic       m_axis_tlast,
    output logic [2:0] m_axis_tuser    // [2:0] status
);

    t_cmd             cmd;
    t_stat            stat;
    logic [LEN_W-1:0] out_index;

    assign o_cfg_ready = 1'b1;

    sig_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    sig_dpath u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_data   (i_cfg_data),
        .i_seq_length (s_axis_tdata[LEN_W-1:0]),
        .i_one_based  (s_axis_tuser),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_out_ready  (m_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .o_index      (out_index),
        .o_last       (m_axis_tlast),
        .o_status     (m_axis_tuser)
    );

    assign m_axis_tdata = {1'b0, out_index};

endmodule

/* bench/tb_slice_index_generator.sv */
// Testbench for slice_index_generator: directed table and random requests checked per item.
`timescale 1ns / 100ps

module tb_slice_index_generator
    import sig_pkg::*;
;

    localparam int          IDLE_LIMIT    = 2000;
    localparam int          LONG_HOLD     = 300;
    localparam int          RANDOM_PHASES = 20;
    localparam int          PHASE_ITEMS   = 12;
    localparam int          NUM_DIRECTED  = 22;
    localparam logic [2:0]  ADDR_UNUSED   = 3'd7;

    typedef struct packed {
        logic [6:0]   index;
        logic         last;
        t_status_code status;
    } t_index_item;

    typedef struct packed {
        logic signed [7:0] start_pos;
        logic              start_open;
        logic signed [7:0] stop_pos;
        logic              stop_open;
        logic signed [7:0] stride;
        logic [6:0]        seq_length;
        logic              one_based;
        logic              typed;
        logic [6:0]        index;
        t_status_code      status;
    } t_slice_case;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [2:0] i_cfg_addr;
    logic [7:0] i_cfg_data;
    logic       s_axis_tvalid;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata;   // [6:0] seq_length, [7] zero
    logic       s_axis_tuser;   // [0] one_based
    logic       m_axis_tvalid;
    logic       m_axis_tready;
    logic [7:0] m_axis_tdata;   // [6:0] index, [7] zero
    logic       m_axis_tlast;
    logic [2:0] m_axis_tuser;   // [2:0] status

    // shadow copy of the slice registers, reset values
    logic signed [7:0] start_pos_q  = 8'sd0;
    logic              start_open_q = 1'b0;
    logic signed [7:0] stop_pos_q   = 8'sd0;
    logic              stop_open_q  = 1'b1;
    logic signed [7:0] stride_q     = 8'sd1;

    t_index_item pending_indices[$];
    t_slice_case dir_cases[NUM_DIRECTED];
    int          error_count = 0;
    int          idle_cycles = 0;
    logic        no_idle     = 1'b0;
    logic        hold_long   = 1'b0;

    slice_index_generator uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Append one expected item at the tail of the queue.
    function automatic void queue_item(input t_index_item item);
        pending_indices.insert(pending_indices.size(), item);
    endfunction

    function automatic void push_single(input t_status_code code);
        t_index_item item;
        item.index  = 7'd0;
        item.last   = 1'b1;
        item.status = code;
        queue_item(item);
    endfunction

    // Normalize the bounds like Python slicing and queue the index run.
    function automatic void predict_slice(input logic [6:0] len_in, input logic one_based);
        int          len;
        int          step;
        int          first;
        int          bound;
        int          pos;
        int          count;
        t_index_item item;
        len  = (int'(len_in) > MAX_LENGTH) ? MAX_LENGTH : int'(len_in);
        step = int'(stride_q);
        if (start_open_q) begin
            first = (step < 0) ? len - 1 : 0;
        end else begin
            first = int'(start_pos_q);
            if (first < 0) first += len;
        end
        if (stop_open_q) begin
            bound = (step < 0) ? -1 : len;
        end else begin
            bound = int'(stop_pos_q);
            if (bound < 0) bound += len;
        end
        if (bound > len) begin
            push_single(ST_STOP_BEYOND);
        end else if (first < 0) begin
            push_single(ST_START_NEG);
        end else if (step == 0) begin
            push_single(ST_ZERO_STEP);
        end else if ((bound >= first && step < 0) || (bound <= first && step > 0)) begin
            push_single(ST_EMPTY);
        end else begin
            count = 0;
            item.status = ST_OK;
            if (step > 0) begin
                for (pos = first; pos < bound && count < MAX_LENGTH; pos += step) begin
                    item.index = 7'(pos + int'(one_based));
                    item.last  = !(pos + step < bound && count + 1 < MAX_LENGTH);
                    queue_item(item);
                    count++;
                end
            end else begin
                if (first > len - 1) first = len - 1;
                if (bound < -1) bound = -1;
                for (pos = first; pos > bound && count < MAX_LENGTH; pos += step) begin
                    item.index = 7'(pos + int'(one_based));
                    item.last  = !(pos + step > bound && count + 1 < MAX_LENGTH);
                    queue_item(item);
                    count++;
                end
            end
            // clamped start can land on the stop
            if (count == 0) push_single(ST_EMPTY);
        end
    endfunction

    task automatic write_reg(input logic [2:0] addr, input logic [7:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (addr)
            ADDR_START_POS:  start_pos_q  = value;
            ADDR_START_OPEN: start_open_q = value[0];
            ADDR_STOP_POS:   stop_pos_q   = value;
            ADDR_STOP_OPEN:  stop_open_q  = value[0];
            ADDR_STRIDE:     stride_q     = value;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Stop offering and wait for every outstanding index.
    task automatic drain_requests();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_indices.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_slice_config(input logic signed [7:0] sp, input logic so,
                                    input logic signed [7:0] tp, input logic to,
                                    input logic signed [7:0] st);
        if (sp != start_pos_q || so != start_open_q || tp != stop_pos_q ||
            to != stop_open_q || st != stride_q) begin
            drain_requests();
            if (sp != start_pos_q)  write_reg(ADDR_START_POS, sp);
            if (so != start_open_q) write_reg(ADDR_START_OPEN, {7'd0, so});
            if (tp != stop_pos_q)   write_reg(ADDR_STOP_POS, tp);
            if (to != stop_open_q)  write_reg(ADDR_STOP_OPEN, {7'd0, to});
            if (st != stride_q)     write_reg(ADDR_STRIDE, st);
        end
    endtask

    task automatic send_request(input logic [6:0] len, input logic ob,
                                input logic typed, input t_index_item typed_item);
        int unsigned gap;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        @(negedge i_clk);
        repeat (gap) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, len};
        s_axis_tuser  <= ob;
        do @(posedge i_clk); while (!s_axis_tready);
        if (typed) queue_item(typed_item);
        else       predict_slice(len, ob);
    endtask

    function automatic logic signed [7:0] random_bound();
        if ($urandom_range(0, 2) == 0) return 8'($urandom_range(0, 128) - 64);
        return 8'($urandom_range(0, 24) - 12);
    endfunction

    function automatic logic signed [7:0] random_stride();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) return 8'sd0;
        if (pick <= 6) begin
            if ($urandom_range(0, 1) == 1) return -8'($urandom_range(1, 4));
            return 8'($urandom_range(1, 4));
        end
        return 8'($urandom_range(0, 128) - 64);
    endfunction

    // Receiver: random stall before each item, one long hold-off on request.
    initial begin
        int unsigned stall;
        while (!i_rst_n) @(negedge i_clk);
        forever begin
            if (hold_long) begin
                stall     = LONG_HOLD;
                hold_long = 1'b0;
            end else begin
                stall = no_idle ? 0 : $urandom_range(0, 3);
            end
            repeat (stall) begin
                m_axis_tready <= 1'b0;
                @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        t_index_item want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_indices.size() == 0) begin
                $error("unexpected item: index %0d last %0b status %0d",
                       m_axis_tdata[6:0], m_axis_tlast, m_axis_tuser);
                error_count++;
            end else begin
                want = pending_indices.pop_front();
                if (m_axis_tdata[6:0] !== want.index) begin
                    $error("index: expected %0d, got %0d", want.index, m_axis_tdata[6:0]);
                    error_count++;
                end
                if (m_axis_tlast !== want.last) begin
                    $error("last: expected %0b, got %0b", want.last, m_axis_tlast);
                    error_count++;
                end
                if (m_axis_tuser !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_axis_tuser);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == IDLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        t_slice_case c;
        t_index_item item;
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_addr    = 3'd0;
        i_cfg_data    = 8'd0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'd0;
        s_axis_tuser  = 1'b0;
        m_axis_tready = 1'b0;

        // start, start_open, stop, stop_open, stride, length, one_based,
        // typed, index, status
        dir_cases = '{
            '{0,   0, 0,   1, 1,   1,   0, 1, 0, ST_OK},          // reset config
            '{0,   0, 0,   1, 1,   1,   1, 1, 1, ST_OK},
            '{0,   0, 0,   1, 1,   0,   0, 1, 0, ST_EMPTY},       // zero length
            '{0,   0, 0,   1, 1,   64,  1, 0, 0, ST_OK},
            '{0,   0, 0,   1, 1,   127, 0, 0, 0, ST_OK},          // length clamps to max
            '{0,   0, 0,   1, 1,   100, 1, 0, 0, ST_OK},
            '{0,   0, 64,  0, 1,   10,  0, 1, 0, ST_STOP_BEYOND},
            '{-64, 0, 0,   1, 1,   10,  1, 1, 0, ST_START_NEG},
            '{0,   0, 0,   1, 0,   10,  0, 1, 0, ST_ZERO_STEP},
            '{0,   1, 0,   1, -1,  0,   1, 1, 0, ST_START_NEG},   // empty seq, step down
            '{0,   1, 0,   1, -1,  64,  0, 0, 0, ST_OK},
            '{64,  0, 0,   1, -1,  10,  1, 0, 0, ST_OK},          // start clamped down
            '{64,  0, 0,   1, 1,   10,  0, 1, 0, ST_EMPTY},       // start past end, step up
            '{64,  0, 10,  0, -1,  10,  0, 1, 0, ST_EMPTY},       // clamped start below stop
            '{0,   1, -64, 0, -3,  10,  1, 0, 0, ST_OK},          // stop clamped to -1
            '{0,   1, 0,   1, 64,  64,  0, 0, 0, ST_OK},
            '{0,   1, 0,   1, -64, 64,  1, 0, 0, ST_OK},
            '{5,   0, 5,   0, -2,  20,  0, 1, 0, ST_EMPTY},
            '{64,  0, -1,  0, 2,   64,  0, 1, 0, ST_EMPTY},
            '{-64, 0, 64,  0, 1,   64,  1, 0, 0, ST_OK},
            '{1,   0, -1,  0, 3,   20,  0, 0, 0, ST_OK},
            '{-64, 0, 64,  0, 0,   10,  0, 1, 0, ST_STOP_BEYOND}  // stop check wins
        };

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_cases[k]) begin
            c = dir_cases[k];
            set_slice_config(c.start_pos, c.start_open, c.stop_pos, c.stop_open, c.stride);
            item.index  = c.index;
            item.last   = 1'b1;
            item.status = c.status;
            send_request(c.seq_length, c.one_based, c.typed, item);
        end

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            drain_requests();
            if (phase == 0) write_reg(ADDR_UNUSED, 8'($urandom()));
            write_reg(ADDR_START_POS, random_bound());
            write_reg(ADDR_START_OPEN, 8'($urandom_range(0, 1)));
            write_reg(ADDR_STOP_POS, random_bound());
            write_reg(ADDR_STOP_OPEN, 8'($urandom_range(0, 1)));
            write_reg(ADDR_STRIDE, random_stride());
            no_idle = (phase % 5 == 2) || (phase == 3);
            // receiver holds off while the sender keeps offering
            if (phase == 3) hold_long = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(0, 3) == 0)
                    send_request(7'($urandom_range(0, 127)), 1'($urandom_range(0, 1)), 1'b0, '0);
                else
                    send_request(7'($urandom_range(0, 24)), 1'($urandom_range(0, 1)), 1'b0, '0);
            end
        end

        drain_requests();
        repeat (8) @(posedge i_clk);
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
